>>> src/heat_diffusion_stencil_step_macros.svh
// Assertion macros shared by the heat diffusion stencil block.
`ifndef HEAT_DIFFUSION_STENCIL_STEP_MACROS_SVH
`define HEAT_DIFFUSION_STENCIL_STEP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define HDS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define HDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/hds_pkg.sv
// Shared types and constants for the heat diffusion stencil block.
package hds_pkg;

  typedef struct packed {
    logic               cmd;
    logic signed [15:0] temperature;
    logic        [15:0] diffusivity;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] new_temperature;
    logic               last_of_frame;
  } out_beat_t;

  typedef logic [1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_GRID_WIDTH     = 2'd0;
  localparam cfg_idx_t CFG_GRID_HEIGHT    = 2'd1;
  localparam cfg_idx_t CFG_TIME_STEP_GAIN = 2'd2;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [8:0]  GRID_WIDTH_RESET     = 9'd256;
  localparam logic [15:0] GRID_HEIGHT_RESET    = 16'd256;
  // dt of about 0.1 in unsigned Q0.16
  localparam logic [15:0] TIME_STEP_GAIN_RESET = 16'd6554;

  localparam logic signed [15:0] TEMP_MAX = 16'sh7fff;
  localparam logic signed [15:0] TEMP_MIN = 16'sh8000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_CAPR,
    ST_LAP,
    ST_MUL,
    ST_FIN
  } ctrl_state_t;

  // Controller to datapath commands for one cycle.
  typedef struct packed {
    logic item_load;
    logic cap_ctr;
    logic cap_l;
    logic cap_r;
    logic calc_lap;
    logic calc_mul;
    logic fin_write_mid;
    logic fin_write_up;
    logic out_load;
    logic t_from_in;
    logic b_from_t;
    logic l_from_u;
    logic r_from_u;
    logic last;
  } dp_cmd_t;

endpackage

>>> src/hds_ctrl.sv
// Sequencer for the heat diffusion stencil: grid position, item decode, read phases.
module hds_ctrl #(
  parameter int MAX_WIDTH = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_cmd,
  output logic                             in_stall,
  input  logic                             out_stall,
  output logic                             out_valid,
  input  logic [8:0]                       grid_width,
  input  logic [15:0]                      grid_height,
  input  logic                             restart,
  output hds_pkg::dp_cmd_t                 cmd,
  output logic [$clog2(MAX_WIDTH)-1:0]     ra_m,
  output logic [$clog2(MAX_WIDTH)-1:0]     ra_u,
  output logic [$clog2(MAX_WIDTH)-1:0]     wa
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);

  hds_pkg::ctrl_state_t state_r, state_nxt;
  logic [AW-1:0] col_r, col_nxt;
  logic [15:0]   row_r, row_nxt;
  logic [AW-1:0] x_r, x_nxt;
  logic          op_load_r, op_load_nxt;
  logic          wr_up_r, wr_up_nxt;
  logic          produce_r, produce_nxt;
  logic          t_in_r, t_in_nxt;
  logic          last_r, last_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [CW-1:0] w_eff;
  logic [15:0]   h_eff;
  logic [AW-1:0] wm1, wm2, a1, a2;
  logic          col_last, out_free;

  always_comb begin
    if (grid_width < 9'd2) begin
      w_eff = CW'(2);
    end else if (32'(grid_width) > MAX_WIDTH) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(grid_width);
    end
  end

  assign h_eff    = (grid_height < 16'd2) ? 16'd2 : grid_height;
  assign wm1      = AW'(w_eff - CW'(1));
  assign wm2      = AW'(w_eff - CW'(2));
  assign col_last = (col_r == wm1);
  assign a1       = (x_r != '0) ? x_r - AW'(1) : AW'(1);
  assign a2       = (x_r != wm1) ? x_r + AW'(1) : wm2;
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hds_pkg::ST_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r       <= x_nxt;
    op_load_r <= op_load_nxt;
    wr_up_r   <= wr_up_nxt;
    produce_r <= produce_nxt;
    t_in_r    <= t_in_nxt;
    last_r    <= last_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    x_nxt       = x_r;
    op_load_nxt = op_load_r;
    wr_up_nxt   = wr_up_r;
    produce_nxt = produce_r;
    t_in_nxt    = t_in_r;
    last_nxt    = last_r;
    cmd         = '0;
    ra_m        = x_r;
    ra_u        = x_r;
    in_stall    = 1'b1;

    cmd.t_from_in = t_in_r;
    cmd.b_from_t  = !op_load_r;
    cmd.l_from_u  = op_load_r && (x_r != '0);
    cmd.r_from_u  = op_load_r && (x_r == wm1);
    cmd.last      = last_r;

    case (state_r)
      hds_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.item_load = 1'b1;
          x_nxt         = col_r;
          t_in_nxt      = (row_r == 16'd1);
          last_nxt      = 1'b0;
          if (in_cmd == hds_pkg::CMD_LOAD) begin
            // loads past the last row are dropped
            if (row_r < h_eff) begin
              op_load_nxt = 1'b1;
              wr_up_nxt   = (row_r != '0);
              produce_nxt = (row_r != '0);
              state_nxt   = (row_r != '0) ? hds_pkg::ST_RD0 : hds_pkg::ST_FIN;
              if (col_last) begin
                col_nxt = '0;
                row_nxt = row_r + 16'd1;
              end else begin
                col_nxt = col_r + AW'(1);
              end
            end
          end else begin
            // drain ticks count only once the last row is in
            if (row_r >= h_eff) begin
              op_load_nxt = 1'b0;
              wr_up_nxt   = 1'b0;
              produce_nxt = 1'b1;
              last_nxt    = col_last;
              state_nxt   = hds_pkg::ST_RD0;
              if (col_last) begin
                col_nxt = '0;
                row_nxt = '0;
              end else begin
                col_nxt = col_r + AW'(1);
              end
            end
          end
        end
      end
      hds_pkg::ST_RD0: begin
        state_nxt = hds_pkg::ST_RD1;
      end
      hds_pkg::ST_RD1: begin
        ra_m        = a1;
        ra_u        = a1;
        cmd.cap_ctr = 1'b1;
        state_nxt   = hds_pkg::ST_RD2;
      end
      hds_pkg::ST_RD2: begin
        ra_m      = a2;
        ra_u      = wm2;
        cmd.cap_l = 1'b1;
        state_nxt = hds_pkg::ST_CAPR;
      end
      hds_pkg::ST_CAPR: begin
        cmd.cap_r = 1'b1;
        state_nxt = hds_pkg::ST_LAP;
      end
      hds_pkg::ST_LAP: begin
        cmd.calc_lap = 1'b1;
        state_nxt    = hds_pkg::ST_MUL;
      end
      hds_pkg::ST_MUL: begin
        cmd.calc_mul = 1'b1;
        state_nxt    = hds_pkg::ST_FIN;
      end
      hds_pkg::ST_FIN: begin
        // hold until the output register can take the result
        if (!produce_r || out_free) begin
          cmd.fin_write_mid = op_load_r;
          cmd.fin_write_up  = wr_up_r;
          cmd.out_load      = produce_r;
          state_nxt         = hds_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = hds_pkg::ST_IDLE;
      end
    endcase

    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;
  assign wa        = x_r;

endmodule

>>> src/hds_datapath.sv
// Row stores, operand capture and fixed-point stencil arithmetic.
module hds_datapath #(
  parameter int MAX_WIDTH = 256
) (
  input  logic                         clk,
  input  hds_pkg::dp_cmd_t             cmd,
  input  logic [$clog2(MAX_WIDTH)-1:0] ra_m,
  input  logic [$clog2(MAX_WIDTH)-1:0] ra_u,
  input  logic [$clog2(MAX_WIDTH)-1:0] wa,
  input  hds_pkg::in_beat_t            in_data,
  input  logic [15:0]                  time_step_gain,
  output hds_pkg::out_beat_t           out_data
);

  logic signed [15:0] mid_mem [MAX_WIDTH];
  logic signed [15:0] up_mem  [MAX_WIDTH];
  logic        [15:0] dif_mem [MAX_WIDTH];

  logic signed [15:0] m_q_r, u_q_r;
  logic        [15:0] d_q_r;
  logic signed [15:0] v_r, c_r, t_r, l_r, r_r;
  logic        [15:0] kin_r, k_r;
  logic               lap_neg_r;
  logic        [17:0] lap_abs_r;
  logic        [31:0] gain_r;
  logic        [49:0] prod_r;
  hds_pkg::out_beat_t out_r;

  logic signed [15:0] b_val;
  logic signed [18:0] lap_nxt, lap_mag;
  logic        [50:0] rnd;
  logic        [18:0] delta;
  logic signed [20:0] c_ext, delta_ext, sum;
  logic signed [15:0] sat;

  always_ff @(posedge clk) begin
    m_q_r <= mid_mem[ra_m];
    u_q_r <= up_mem[ra_u];
    d_q_r <= dif_mem[ra_m];
    if (cmd.fin_write_mid) begin
      mid_mem[wa] <= v_r;
      dif_mem[wa] <= kin_r;
    end
    if (cmd.fin_write_up) begin
      up_mem[wa] <= c_r;
    end
  end

  assign b_val   = cmd.b_from_t ? t_r : v_r;
  assign lap_nxt = {{3{l_r[15]}}, l_r} + {{3{r_r[15]}}, r_r}
                 + {{3{t_r[15]}}, t_r} + {{3{b_val[15]}}, b_val}
                 - {c_r[15], c_r, 2'b00};
  assign lap_mag = lap_nxt[18] ? -lap_nxt : lap_nxt;

  // round half away from zero on the magnitude, then restore the sign
  assign rnd       = {1'b0, prod_r} + 51'h0_0000_8000_0000;
  assign delta     = rnd[50:32];
  assign c_ext     = {{5{c_r[15]}}, c_r};
  assign delta_ext = {2'b00, delta};
  assign sum       = lap_neg_r ? c_ext - delta_ext : c_ext + delta_ext;

  always_comb begin
    if (sum > 21'sd32767) begin
      sat = hds_pkg::TEMP_MAX;
    end else if (sum < -21'sd32768) begin
      sat = hds_pkg::TEMP_MIN;
    end else begin
      sat = sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      v_r   <= in_data.temperature;
      kin_r <= in_data.diffusivity;
    end
    if (cmd.cap_ctr) begin
      c_r <= m_q_r;
      t_r <= cmd.t_from_in ? v_r : u_q_r;
      k_r <= d_q_r;
    end
    if (cmd.cap_l) begin
      l_r <= cmd.l_from_u ? u_q_r : m_q_r;
    end
    if (cmd.cap_r) begin
      r_r <= cmd.r_from_u ? u_q_r : m_q_r;
    end
    if (cmd.calc_lap) begin
      lap_neg_r <= lap_nxt[18];
      lap_abs_r <= lap_mag[17:0];
      gain_r    <= 32'(k_r) * 32'(time_step_gain);
    end
    if (cmd.calc_mul) begin
      prod_r <= 50'(lap_abs_r) * 50'(gain_r);
    end
    if (cmd.out_load) begin
      out_r.new_temperature <= sat;
      out_r.last_of_frame   <= cmd.last;
    end
  end

  assign out_data = out_r;

endmodule

>>> src/heat_diffusion_stencil_step.sv
// Top level of the heat diffusion stencil: config registers, sequencer and datapath.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+----------------------------------
//   in_*     | input     | in_valid / in_stall | cmd, temperature, diffusivity
//   out_*    | output    | out_valid/out_stall | new_temperature, last_of_frame
//   cfg_*    | input     | cfg_we              | cfg_index, cfg_data (16 bits)
//
// A beat that yields a result (row 1 and later loads, drain ticks) has three read
// phases on the single-read-port row stores, then Laplacian, multiply and finish
// stages. A row 0 load skips to the finish stage; a dropped beat stays in idle.
// rst_n (synchronous) clears the config registers, sequencer, grid position and
// output valid; the row stores hold garbage until the first rows of a frame write
// them. A stalled output holds its result; the next beat is still accepted and works
// up to its finish stage, where it waits for the output register.

`include "heat_diffusion_stencil_step_macros.svh"

module heat_diffusion_stencil_step #(
  parameter int MAX_WIDTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hds_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output hds_pkg::out_beat_t out_data,
  input  logic               cfg_we,
  input  hds_pkg::cfg_idx_t  cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic [8:0]  grid_width_r;
  logic [15:0] grid_height_r;
  logic [15:0] time_step_gain_r;
  logic        restart;

  hds_pkg::dp_cmd_t dp_cmd;
  logic [AW-1:0]    ra_m, ra_u, wa;

  // User keeps config writes to idle (unchecked); geometry writes restart the frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r     <= hds_pkg::GRID_WIDTH_RESET;
      grid_height_r    <= hds_pkg::GRID_HEIGHT_RESET;
      time_step_gain_r <= hds_pkg::TIME_STEP_GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        hds_pkg::CFG_GRID_WIDTH:     grid_width_r     <= cfg_data[8:0];
        hds_pkg::CFG_GRID_HEIGHT:    grid_height_r    <= cfg_data;
        hds_pkg::CFG_TIME_STEP_GAIN: time_step_gain_r <= cfg_data;
        default: begin
          // unused index: drop the write
        end
      endcase
    end
  end

  assign restart = cfg_we && ((cfg_index == hds_pkg::CFG_GRID_WIDTH) ||
                              (cfg_index == hds_pkg::CFG_GRID_HEIGHT));

  // Sequencer: owns the grid position and walks each beat through its phases.
  hds_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_cmd      (in_data.cmd),
    .in_stall    (in_stall),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .grid_width  (grid_width_r),
    .grid_height (grid_height_r),
    .restart     (restart),
    .cmd         (dp_cmd),
    .ra_m        (ra_m),
    .ra_u        (ra_u),
    .wa          (wa)
  );

  // Datapath: row stores plus the stencil arithmetic and output register.
  hds_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .cmd            (dp_cmd),
    .ra_m           (ra_m),
    .ra_u           (ra_u),
    .wa             (wa),
    .in_data        (in_data),
    .time_step_gain (time_step_gain_r),
    .out_data       (out_data)
  );

  // A result shows up only from a beat that was in flight the cycle before.
  `HDS_ASSERT_SAME(a_result_from_work, $rose(out_valid), $past(in_stall), "result without beat in flight")
  // No result appears in the cycle right after a beat is accepted.
  `HDS_ASSERT_NEXT(a_min_latency, in_valid && !in_stall, !$rose(out_valid), "result too early after accept")

endmodule
